### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY_DEF = 512;
    localparam int TAG_BITS_DEF = 9;

    localparam int KEY_W   = 24;
    localparam int TAG_W   = 9;
    localparam int COUNT_W = 10;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [KEY_W-1:0]   key;
        logic [TAG_W-1:0]   tag;
    } spq_req_t;

    typedef struct packed {
        logic               ok;
        logic [KEY_W-1:0]   out_key;
        logic [TAG_W-1:0]   out_tag;
        logic [COUNT_W-1:0] count;
        logic               empty_res;
    } spq_rsp_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [KEY_W-1:0] key;
    } spq_cmd_t;

endpackage

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a key and a tag, compares against the
// broadcast key and shifts up on push or down on pop.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int INDEX    = 0,
    parameter int FILL_W   = 10,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
    input  logic                       clk,
    input  spq_pkg::spq_cmd_t          cmd,
    input  logic [TAG_BITS-1:0]        new_tag,
    input  logic [FILL_W-1:0]          fill,
    input  logic                       prev_ge,
    input  logic [spq_pkg::KEY_W-1:0]  prev_key,
    input  logic [TAG_BITS-1:0]        prev_tag,
    input  logic [spq_pkg::KEY_W-1:0]  next_key,
    input  logic [TAG_BITS-1:0]        next_tag,
    output logic                       ge,
    output logic [spq_pkg::KEY_W-1:0]  key,
    output logic [TAG_BITS-1:0]        tag
);

    logic [spq_pkg::KEY_W-1:0] key_reg, key_next;
    logic [TAG_BITS-1:0]       tag_reg, tag_next;

    // An unoccupied slot counts as "at or after the insert point", so the
    // sorted region plus the first free slot form a monotone boundary.
    assign ge = (FILL_W'(INDEX) >= fill) || (key_reg > cmd.key);

    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        priority if (cmd.push && prev_ge)
        begin
            key_next = prev_key;
            tag_next = prev_tag;
        end
        else if (cmd.push && ge)
        begin
            key_next = cmd.key;
            tag_next = new_tag;
        end
        else if (cmd.pop)
        begin
            key_next = next_key;
            tag_next = next_tag;
        end
        else
        begin
            key_next = key_reg;
            tag_next = tag_reg;
        end
    end

    // Payload only; occupancy is tracked by the fill count at the top.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

### rtl/stable_sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_core
// Min-priority queue of (key, tag) entries held in ascending order.
// ----------------------------------------------------------------------------
// Usage: the request channel (req_valid, req_ready, req) carries a push of
// (key, tag) or a pop. Every request gives one response on the response
// channel (rsp_valid, rsp_ready, rsp): the ok flag, the popped key and tag
// (zero on a push or a failed pop), the entry count and the empty flag.
// Entries with equal keys leave in the order in which they were pushed.
// A push on a full queue and a pop on an empty one return ok low and leave
// the queue unchanged.
// The response is registered and shows in the cycle after its request is taken.
// One request is taken per cycle as long as the response side takes its
// results; the whole chain of cells compares against the new key and shifts.
// When the receiver stalls, the response is held in its output register and
// req_ready drops until it is taken.
// Reset empties the queue at once by clearing the fill count; the cell
// contents need no clearing.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_core #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  spq_pkg::spq_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output spq_pkg::spq_rsp_t rsp
);

    localparam int FILL_W = $clog2(CAPACITY + 1);

    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               rsp_valid_reg, rsp_valid_next;
    spq_pkg::spq_rsp_t  rsp_reg, rsp_next;

    logic               accept, full, empty, push_do, pop_do;
    spq_pkg::spq_cmd_t  cmd;
    logic [TAG_BITS-1:0] new_tag;

    logic                      cell_ge  [CAPACITY];
    logic [spq_pkg::KEY_W-1:0] cell_key [CAPACITY];
    logic [TAG_BITS-1:0]       cell_tag [CAPACITY];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign full      = (fill_reg == FILL_W'(CAPACITY));
    assign empty     = (fill_reg == '0);
    assign push_do   = accept && (req.req_type == spq_pkg::REQ_PUSH) && !full;
    assign pop_do    = accept && (req.req_type == spq_pkg::REQ_POP) && !empty;

    assign cmd.push = push_do;
    assign cmd.pop  = pop_do;
    assign cmd.key  = req.key;
    assign new_tag  = TAG_BITS'(req.tag);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                      p_ge;
            logic [spq_pkg::KEY_W-1:0] p_key, n_key;
            logic [TAG_BITS-1:0]       p_tag, n_tag;

            if (gi == 0)
            begin : g_first
                assign p_ge  = 1'b0;
                assign p_key = cell_key[gi];
                assign p_tag = cell_tag[gi];
            end
            else
            begin : g_mid
                assign p_ge  = cell_ge[gi-1];
                assign p_key = cell_key[gi-1];
                assign p_tag = cell_tag[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign n_key = cell_key[gi];
                assign n_tag = cell_tag[gi];
            end
            else
            begin : g_body
                assign n_key = cell_key[gi+1];
                assign n_tag = cell_tag[gi+1];
            end

            spq_cell #(
                .INDEX    (gi),
                .FILL_W   (FILL_W),
                .TAG_BITS (TAG_BITS)
            ) u_cell (
                .clk      (clk),
                .cmd      (cmd),
                .new_tag  (new_tag),
                .fill     (fill_reg),
                .prev_ge  (p_ge),
                .prev_key (p_key),
                .prev_tag (p_tag),
                .next_key (n_key),
                .next_tag (n_tag),
                .ge       (cell_ge[gi]),
                .key      (cell_key[gi]),
                .tag      (cell_tag[gi])
            );
        end
    endgenerate

    always_comb
    begin
        fill_next = fill_reg;
        priority if (push_do)
            fill_next = fill_reg + FILL_W'(1);
        else if (pop_do)
            fill_next = fill_reg - FILL_W'(1);
        else
            fill_next = fill_reg;

        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        priority if (accept)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.ok        = push_do || pop_do;
            rsp_next.out_key   = pop_do ? cell_key[0] : '0;
            rsp_next.out_tag   = pop_do ? spq_pkg::TAG_W'(cell_tag[0]) : '0;
            rsp_next.count     = spq_pkg::COUNT_W'(fill_next);
            rsp_next.empty_res = (fill_next == '0);
        end
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The fill count never runs past the number of cells.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    // Every accepted request leaves a response behind it.
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted request gave no response");

    // A pop on an empty queue reports failure and an empty queue.
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == spq_pkg::REQ_POP && empty)
        |=> (!rsp_reg.ok && rsp_reg.empty_res))
        else $error("pop on empty queue misreported");

    // The head of the chain stays in ascending order.
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg >= FILL_W'(2)) |-> (cell_key[0] <= cell_key[1]))
        else $error("head cells out of order");

endmodule

### dv/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Watches both channels of the priority queue, predicts every response from
// a queue of its own and compares each field of what comes back.
// ----------------------------------------------------------------------------
module spq_checker #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  spq_pkg::spq_req_t req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  spq_pkg::spq_rsp_t rsp,
    output int                errors,
    output int                outstanding,
    output int                answered,
    output int                full_refusals,
    output int                empty_refusals,
    output int                peak_fill
);

    localparam logic [spq_pkg::TAG_W-1:0] TAG_KEEP =
        spq_pkg::TAG_W'((1 << TAG_BITS) - 1);

    // Entries held in ascending key order, index 0 leaves first.
    logic [spq_pkg::KEY_W-1:0] held_keys[$];
    logic [spq_pkg::TAG_W-1:0] held_tags[$];
    spq_pkg::spq_rsp_t         due_rsp[$];

    function automatic spq_pkg::spq_rsp_t queue_step(input spq_pkg::spq_req_t r);
        spq_pkg::spq_rsp_t res;
        int                pos;
        res = '0;
        if (r.req_type == spq_pkg::REQ_PUSH)
        begin
            if (held_keys.size() >= CAPACITY)
            begin
                full_refusals++;
            end
            else
            begin
                // Equal keys go behind the ones already held.
                pos = 0;
                while (pos < held_keys.size() && held_keys[pos] <= r.key)
                    pos++;
                held_keys.insert(pos, r.key);
                held_tags.insert(pos, r.tag & TAG_KEEP);
                res.ok = 1'b1;
            end
        end
        else
        begin
            if (held_keys.size() == 0)
            begin
                empty_refusals++;
            end
            else
            begin
                res.ok      = 1'b1;
                res.out_key = held_keys.pop_front();
                res.out_tag = held_tags.pop_front();
            end
        end
        res.count     = spq_pkg::COUNT_W'(held_keys.size());
        res.empty_res = (held_keys.size() == 0);
        if (held_keys.size() > peak_fill)
            peak_fill = held_keys.size();
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        spq_pkg::spq_rsp_t want;
        string             bad;
        if (!rst_n)
        begin
            held_keys.delete();
            held_tags.delete();
            due_rsp.delete();
            errors         = 0;
            answered       = 0;
            full_refusals  = 0;
            empty_refusals = 0;
            peak_fill      = 0;
            outstanding   <= 0;
        end
        else
        begin
            // A response always belongs to a request taken at an earlier edge.
            if (rsp_valid && rsp_ready)
            begin
                if (due_rsp.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"[%0t] response with no request pending: ",
                                  "ok=%0b key=%h tag=%h count=%0d empty=%0b"},
                                 $time, rsp.ok, rsp.out_key, rsp.out_tag,
                                 rsp.count, rsp.empty_res);
                end
                else
                begin
                    want = due_rsp.pop_front();
                    bad  = "";
                    if (rsp.ok !== want.ok)
                        bad = {bad, " ok"};
                    if (rsp.out_key !== want.out_key)
                        bad = {bad, " out_key"};
                    if (rsp.out_tag !== want.out_tag)
                        bad = {bad, " out_tag"};
                    if (rsp.count !== want.count)
                        bad = {bad, " count"};
                    if (rsp.empty_res !== want.empty_res)
                        bad = {bad, " empty_res"};
                    if (bad != "")
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("[%0t] response %0d wrong in%s", $time, answered, bad);
                            $display("    expected ok=%0b key=%h tag=%h count=%0d empty=%0b",
                                     want.ok, want.out_key, want.out_tag, want.count,
                                     want.empty_res);
                            $display("    actual   ok=%0b key=%h tag=%h count=%0d empty=%0b",
                                     rsp.ok, rsp.out_key, rsp.out_tag, rsp.count,
                                     rsp.empty_res);
                        end
                    end
                    answered++;
                end
            end
            if (req_valid && req_ready)
                due_rsp.push_back(queue_step(req));
            outstanding <= due_rsp.size();
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives push and pop requests into the stable priority queue under several
// idle profiles, fills it to capacity and drains it, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CAP         = spq_pkg::CAPACITY_DEF;
    localparam int LONG_HOLD   = 150;
    localparam int CYCLE_LIMIT = 300000;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    spq_pkg::spq_req_t req       = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    spq_pkg::spq_rsp_t rsp;

    int errors;
    int outstanding;
    int answered;
    int full_refusals;
    int empty_refusals;
    int peak_fill;

    int req_idle_pct = 0;
    int rsp_idle_pct = 0;
    int hold_asks    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int level        = 0;
    int sent         = 0;
    int cycles       = 0;

    stable_sorted_priority_queue_core #(
        .CAPACITY (CAP),
        .TAG_BITS (spq_pkg::TAG_BITS_DEF)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    spq_checker #(
        .CAPACITY (CAP),
        .TAG_BITS (spq_pkg::TAG_BITS_DEF)
    ) u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .errors         (errors),
        .outstanding    (outstanding),
        .answered       (answered),
        .full_refusals  (full_refusals),
        .empty_refusals (empty_refusals),
        .peak_fill      (peak_fill)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d responses pending.",
                     cycles, outstanding);
            $display("stable_sorted_priority_queue_core verification failed");
            $finish;
        end
    end

    // Response side: random stalls, plus a long hold-off each time one is asked.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // Keys lean toward zero, small values up to 7 and values near the top so that ties are common.
    function automatic logic [spq_pkg::KEY_W-1:0] pick_key();
        unique case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return spq_pkg::KEY_W'($urandom_range(7));
            5:       return spq_pkg::KEY_W'($urandom_range(24'hFFFFFF, 24'hFFFFF8));
            default: return spq_pkg::KEY_W'($urandom);
        endcase
    endfunction

    task automatic send_op(input logic op, input logic [spq_pkg::KEY_W-1:0] k,
                           input logic [spq_pkg::TAG_W-1:0] t);
        req       <= '{req_type: op, key: k, tag: t};
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sent++;
        if (op == spq_pkg::REQ_PUSH)
        begin
            if (level < CAP)
                level++;
        end
        else if (level > 0)
        begin
            level--;
        end
        if ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < req_idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic random_mix(input int n);
        repeat (n)
        begin
            send_op(($urandom_range(99) < 45) ? spq_pkg::REQ_POP : spq_pkg::REQ_PUSH,
                    pick_key(), spq_pkg::TAG_W'($urandom_range(511)));
        end
    endtask

    // The checker's outstanding count is registered, so look from the cycle after valid drops.
    task automatic wait_all_answered();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int send_pct[3];
        int recv_pct[3];
        send_pct = '{28, 47, 0};
        recv_pct = '{47, 28, 0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Pop from empty, extreme keys and tags, and a run of equal keys.
        send_op(spq_pkg::REQ_POP,  24'hFFFFFF, 9'h1FF);
        send_op(spq_pkg::REQ_PUSH, 24'h000000, 9'h000);
        send_op(spq_pkg::REQ_PUSH, 24'hFFFFFF, 9'h1FF);
        send_op(spq_pkg::REQ_PUSH, 24'h000005, 9'h001);
        send_op(spq_pkg::REQ_PUSH, 24'h000005, 9'h002);
        send_op(spq_pkg::REQ_PUSH, 24'h000005, 9'h003);
        send_op(spq_pkg::REQ_PUSH, 24'h000000, 9'h155);
        send_op(spq_pkg::REQ_PUSH, 24'hFFFFFF, 9'h0AA);
        repeat (7)
            send_op(spq_pkg::REQ_POP, 24'h5A5A5A, 9'h0F0);
        send_op(spq_pkg::REQ_POP,  24'h000000, 9'h000);
        send_op(spq_pkg::REQ_PUSH, 24'h800000, 9'h100);
        send_op(spq_pkg::REQ_PUSH, 24'h7FFFFF, 9'h0FF);
        send_op(spq_pkg::REQ_POP,  24'h000000, 9'h000);
        send_op(spq_pkg::REQ_POP,  24'hFFFFFF, 9'h1FF);
        wait_all_answered();

        for (int m = 0; m < 3; m++)
        begin
            req_idle_pct  = send_pct[m];
            rsp_idle_pct <= recv_pct[m];
            random_mix(75);
            if (m == 0)
                hold_asks <= hold_asks + 1;
            random_mix(75);
            wait_all_answered();
        end

        // Ask for a long receiver hold-off, fill to capacity, overrun, then drain.
        hold_asks <= hold_asks + 1;
        while (level < CAP)
            send_op(spq_pkg::REQ_PUSH, pick_key(), spq_pkg::TAG_W'($urandom_range(511)));
        repeat (3)
            send_op(spq_pkg::REQ_PUSH, pick_key(), spq_pkg::TAG_W'($urandom_range(511)));
        while (level > 0)
            send_op(spq_pkg::REQ_POP, pick_key(), spq_pkg::TAG_W'($urandom_range(511)));
        repeat (2)
            send_op(spq_pkg::REQ_POP, pick_key(), spq_pkg::TAG_W'($urandom_range(511)));

        wait_all_answered();
        repeat (20) @(posedge clk);

        $display({"Sent %0d requests over three idle profiles and two long receiver ",
                  "holds; %0d responses checked."}, sent, answered);
        $display("Peak fill %0d of %0d, %0d pushes refused as full, %0d pops refused as empty.",
                 peak_fill, CAP, full_refusals, empty_refusals);
        if (errors == 0 && outstanding == 0)
            $display("stable_sorted_priority_queue_core verification clean");
        else
            $display("stable_sorted_priority_queue_core verification failed");
        $finish;
    end

endmodule

### files.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_sorted_priority_queue_core.sv
dv/spq_checker.sv
dv/tb_top.sv
